// ===== rtl/bmpad_pkg.sv =====
// ----------------------------------------------------------------------------
// bmpad_pkg
// Shared types and constants of the BMP pixel array decoder: register
// indexes, item codes, status codes, depth codes and sequencer states.
// ----------------------------------------------------------------------------
package bmpad_pkg;

   localparam int DEF_MAX_WIDTH     = 4096;
   localparam int DEF_PALETTE_DEPTH = 256;

   localparam int DEPTH_MODE_W  = 3;
   localparam int IMG_WIDTH_W   = 13;
   localparam int COLORS_W      = 9;
   localparam int CSR_ADDR_W    = 2;
   localparam int CSR_DATA_W    = 13;
   localparam int PIX_COL_W     = 12;
   localparam int COLOR_W       = 24;
   localparam int STATUS_W      = 2;

   // configuration register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_DEPTH_MODE  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_WIDTH = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_COLORS      = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_GRAY_ONLY   = 2'd3;

   // input item kinds
   localparam logic [1:0] OP_PAL_WRITE  = 2'd0;
   localparam logic [1:0] OP_PIXEL_BYTE = 2'd1;
   localparam logic [1:0] OP_NEW_FRAME  = 2'd2;

   // result status
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INDEX = 2'd1;
   localparam logic [STATUS_W-1:0] ST_GRAY  = 2'd2;

   // depth codes
   localparam logic [DEPTH_MODE_W-1:0] MODE_1BPP  = 3'd0;
   localparam logic [DEPTH_MODE_W-1:0] MODE_2BPP  = 3'd1;
   localparam logic [DEPTH_MODE_W-1:0] MODE_4BPP  = 3'd2;
   localparam logic [DEPTH_MODE_W-1:0] MODE_8BPP  = 3'd3;
   localparam logic [DEPTH_MODE_W-1:0] MODE_24BPP = 3'd4;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_DECODE,
      SEQ_EMIT
   } seq_state_type;

   typedef struct packed {
      logic [DEPTH_MODE_W-1:0] depth_mode;
      logic [IMG_WIDTH_W-1:0]  image_width;
      logic [COLORS_W-1:0]     colors_in_table;
      logic                    gray_only;
   } cfg_type;

   typedef struct packed {
      logic               en;
      logic [7:0]         index;
      logic [COLOR_W-1:0] color;   // red, green, blue from high bits down
   } pal_wr_type;

endpackage

// ===== rtl/bmpad_palette.sv =====
// ----------------------------------------------------------------------------
// bmpad_palette
// Palette memory: one write port for palette loads, one read port with
// registered read data for index lookup.
// ----------------------------------------------------------------------------
module bmpad_palette
   import bmpad_pkg::*;
#(
   parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH,
   localparam int ADDR_W = $clog2(PALETTE_DEPTH)
) (
   input  logic               clock,
   input  pal_wr_type         wr,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [COLOR_W-1:0] rd_color
);

   logic [COLOR_W-1:0] mem [PALETTE_DEPTH];
   logic [COLOR_W-1:0] rd_color_ff;

   // drop writes beyond the store
   always_ff @(posedge clock) begin
      if (wr.en && ({1'b0, wr.index} < 9'(PALETTE_DEPTH))) begin
         mem[wr.index[ADDR_W-1:0]] <= wr.color;
      end
   end

   always_ff @(posedge clock) begin
      rd_color_ff <= mem[rd_addr];
   end

   assign rd_color = rd_color_ff;

endmodule

// ===== rtl/bmpad_seq.sv =====
// ----------------------------------------------------------------------------
// bmpad_seq
// Byte sequencer: row byte and column counters, 24 bit color assembly,
// and one shared index extract / compare unit stepped once per pixel,
// feeding the result output register.
// ----------------------------------------------------------------------------
module bmpad_seq
   import bmpad_pkg::*;
#(
   parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
   parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH,
   localparam int ADDR_W = $clog2(PALETTE_DEPTH)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   // input words
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [1:0]           in_op,
   input  logic [7:0]           in_data_byte,
   input  logic [7:0]           in_pal_index,
   input  logic [COLOR_W-1:0]   in_pal_color,
   // palette
   output pal_wr_type           pal_wr,
   output logic [ADDR_W-1:0]    pal_rd_addr,
   input  logic [COLOR_W-1:0]   pal_color,
   // result words
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [COLOR_W-1:0]   out_color,
   output logic [PIX_COL_W-1:0] out_column,
   output logic                 out_row_end,
   output logic                 out_last,
   output logic [STATUS_W-1:0]  out_status
);

   localparam int CLOG_W = $clog2(MAX_WIDTH + 1);
   localparam int COL_W  = (CLOG_W < IMG_WIDTH_W) ? CLOG_W : IMG_WIDTH_W;
   localparam int RBC_W  = COL_W + 2;
   localparam int WMAX   = (MAX_WIDTH < (2 ** IMG_WIDTH_W - 1)) ? MAX_WIDTH
                                                                : (2 ** IMG_WIDTH_W - 1);
   localparam logic [IMG_WIDTH_W-1:0] WMAX_V = IMG_WIDTH_W'(WMAX);
   localparam logic [COLORS_W-1:0]    PD_V   = COLORS_W'(PALETTE_DEPTH);
   localparam logic [ADDR_W-1:0]      ADDR_MASK = ADDR_W'(PALETTE_DEPTH - 1);

   function automatic logic [7:0] idx_of(input logic [7:0] sh,
                                         input logic [DEPTH_MODE_W-1:0] m);
      logic [7:0] r;
      case (m)
         MODE_1BPP: r = {7'd0, sh[7]};
         MODE_2BPP: r = {6'd0, sh[7:6]};
         MODE_4BPP: r = {4'd0, sh[7:4]};
         default:   r = sh;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] shift_of(input logic [7:0] sh,
                                           input logic [DEPTH_MODE_W-1:0] m);
      logic [7:0] r;
      case (m)
         MODE_1BPP: r = {sh[6:0], 1'b0};
         MODE_2BPP: r = {sh[5:0], 2'd0};
         MODE_4BPP: r = {sh[3:0], 4'd0};
         default:   r = 8'd0;
      endcase
      return r;
   endfunction

   seq_state_type      state_ff, state_in;
   logic [7:0]         byte_ff, byte_in;
   logic [15:0]        partial_ff, partial_in;
   logic [1:0]         phase_ff, phase_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [RBC_W-1:0]   rbc_ff, rbc_in;
   logic               err_ff, err_in;
   logic               is24_ff, is24_in;
   logic [2:0]         pix_ff, pix_in;
   logic               out_valid_ff, out_valid_in;
   logic [COLOR_W-1:0] out_color_ff, out_color_in;
   logic [PIX_COL_W-1:0] out_col_ff, out_col_in;
   logic               out_row_end_ff, out_row_end_in;
   logic               out_last_ff, out_last_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;

   logic [DEPTH_MODE_W-1:0] mode;
   logic [IMG_WIDTH_W-1:0]  w_clamp;
   logic [COL_W-1:0]        width;
   logic [RBC_W-1:0]        wext, data_bytes, stride, rbc_p1;
   logic [COLORS_W-1:0]     full_count, count_raw, count;
   logic [2:0]              last_pix;
   logic [7:0]              cur_idx, next_sh, next_idx;
   logic                    cur_err;
   logic [COLOR_W-1:0]      src;
   logic                    gray_bad;
   logic [STATUS_W-1:0]     st;
   logic [COL_W:0]          col_p1;
   logic                    out_free, fire, more, advance, wrap;

   // frame geometry, palette limits; user keeps cfg stable while item in work
   always_comb begin
      mode = (cfg.depth_mode > MODE_24BPP) ? MODE_24BPP : cfg.depth_mode;
      w_clamp = (cfg.image_width > WMAX_V) ? WMAX_V : cfg.image_width;
      if (w_clamp == '0) begin
         w_clamp = IMG_WIDTH_W'(1);
      end
      width = COL_W'(w_clamp);
      wext  = RBC_W'(width);
      case (mode)
         MODE_1BPP: begin
            data_bytes = (wext + RBC_W'(7)) >> 3;
            full_count = COLORS_W'(2);
            last_pix   = 3'd7;
         end
         MODE_2BPP: begin
            data_bytes = (wext + RBC_W'(3)) >> 2;
            full_count = COLORS_W'(4);
            last_pix   = 3'd3;
         end
         MODE_4BPP: begin
            data_bytes = (wext + RBC_W'(1)) >> 1;
            full_count = COLORS_W'(16);
            last_pix   = 3'd1;
         end
         MODE_8BPP: begin
            data_bytes = wext;
            full_count = COLORS_W'(256);
            last_pix   = 3'd0;
         end
         default: begin
            data_bytes = wext + (wext << 1);
            full_count = COLORS_W'(256);
            last_pix   = 3'd0;
         end
      endcase
      stride = (data_bytes + RBC_W'(3)) & ~RBC_W'(3);
      count_raw = (cfg.colors_in_table == '0) ? full_count : cfg.colors_in_table;
      count = (count_raw > PD_V) ? PD_V : count_raw;
   end

   // shared index unit: extract, compare, step to the next pixel
   always_comb begin
      cur_idx  = idx_of(byte_ff, mode);
      cur_err  = {1'b0, cur_idx} >= count;
      next_sh  = shift_of(byte_ff, mode);
      next_idx = idx_of(next_sh, mode);

      src = is24_ff ? {byte_ff, partial_ff[15:8], partial_ff[7:0]} : pal_color;
      gray_bad = cfg.gray_only &&
                 !((src[23:16] == src[15:8]) && (src[15:8] == src[7:0]));
      if (!is24_ff && cur_err) begin
         st = ST_INDEX;
      end else if (gray_bad) begin
         st = ST_GRAY;
      end else begin
         st = ST_OK;
      end

      col_p1   = {1'b0, col_ff} + (COL_W + 1)'(1);
      out_free = !out_valid_ff || out_ready;
      fire     = (state_ff == SEQ_EMIT) && out_free;
      more     = !is24_ff && (pix_ff != last_pix) && (col_p1 < {1'b0, width}) &&
                 (st == ST_OK);
      advance  = fire && more;
      rbc_p1   = rbc_ff + RBC_W'(1);
      wrap     = rbc_p1 >= stride;

      pal_rd_addr = (advance ? next_idx[ADDR_W-1:0] : cur_idx[ADDR_W-1:0]) & ADDR_MASK;
   end

   always_comb begin
      state_in       = state_ff;
      byte_in        = byte_ff;
      partial_in     = partial_ff;
      phase_in       = phase_ff;
      col_in         = col_ff;
      rbc_in         = rbc_ff;
      err_in         = err_ff;
      is24_in        = is24_ff;
      pix_in         = pix_ff;
      out_valid_in   = out_valid_ff && !out_ready;
      out_color_in   = out_color_ff;
      out_col_in     = out_col_ff;
      out_row_end_in = out_row_end_ff;
      out_last_in    = out_last_ff;
      out_status_in  = out_status_ff;
      in_ready       = (state_ff == SEQ_IDLE);
      pal_wr.en      = 1'b0;
      pal_wr.index   = in_pal_index;
      pal_wr.color   = in_pal_color;

      case (state_ff)
         SEQ_IDLE: begin
            if (in_valid) begin
               case (in_op)
                  OP_PAL_WRITE: begin
                     pal_wr.en = 1'b1;
                  end
                  OP_NEW_FRAME: begin
                     col_in     = '0;
                     rbc_in     = '0;
                     partial_in = '0;
                     phase_in   = '0;
                     err_in     = 1'b0;
                  end
                  OP_PIXEL_BYTE: begin
                     if (!err_ff) begin
                        byte_in  = in_data_byte;
                        state_in = SEQ_DECODE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         SEQ_DECODE: begin
            state_in = SEQ_IDLE;
            pix_in   = '0;
            is24_in  = (mode == MODE_24BPP);
            if (rbc_ff < data_bytes) begin
               if (mode == MODE_24BPP) begin
                  case (phase_ff)
                     2'd0: begin
                        partial_in[7:0] = byte_ff;
                        phase_in        = 2'd1;
                     end
                     2'd1: begin
                        partial_in[15:8] = byte_ff;
                        phase_in         = 2'd2;
                     end
                     default: begin
                        phase_in = 2'd0;
                        if (col_ff < width) begin
                           state_in = SEQ_EMIT;
                        end
                     end
                  endcase
               end else if (col_ff < width) begin
                  state_in = SEQ_EMIT;
               end
            end
            // no pixel from this byte: advance the row now
            if (state_in == SEQ_IDLE) begin
               rbc_in = wrap ? '0 : rbc_p1;
               if (wrap) begin
                  col_in   = '0;
                  phase_in = '0;
               end
            end
         end

         SEQ_EMIT: begin
            if (fire) begin
               out_valid_in   = 1'b1;
               out_color_in   = (st == ST_INDEX) ? '0 : src;
               out_col_in     = PIX_COL_W'(col_ff);
               out_row_end_in = (col_p1 == {1'b0, width});
               out_last_in    = !more;
               out_status_in  = st;
               col_in         = col_p1[COL_W-1:0];
               if (st != ST_OK) begin
                  err_in = 1'b1;
               end
               if (more) begin
                  byte_in = next_sh;
                  pix_in  = pix_ff + 3'd1;
               end else begin
                  state_in = SEQ_IDLE;
                  rbc_in   = wrap ? '0 : rbc_p1;
                  if (wrap) begin
                     col_in   = '0;
                     phase_in = '0;
                  end
               end
            end
         end

         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         partial_ff   <= '0;
         phase_ff     <= '0;
         col_ff       <= '0;
         rbc_ff       <= '0;
         err_ff       <= 1'b0;
         is24_ff      <= 1'b0;
         pix_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         partial_ff   <= partial_in;
         phase_ff     <= phase_in;
         col_ff       <= col_in;
         rbc_ff       <= rbc_in;
         err_ff       <= err_in;
         is24_ff      <= is24_in;
         pix_ff       <= pix_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff        <= byte_in;
      out_color_ff   <= out_color_in;
      out_col_ff     <= out_col_in;
      out_row_end_ff <= out_row_end_in;
      out_last_ff    <= out_last_in;
      out_status_ff  <= out_status_in;
   end

   assign out_valid   = out_valid_ff;
   assign out_color   = out_color_ff;
   assign out_column  = out_col_ff;
   assign out_row_end = out_row_end_ff;
   assign out_last    = out_last_ff;
   assign out_status  = out_status_ff;

   a_busy_without_error: assert property (@(posedge clock) disable iff (reset)
      (state_ff != SEQ_IDLE) |-> !err_ff)
      else $error("byte in work while error is latched");

   a_error_ends_byte: assert property (@(posedge clock) disable iff (reset)
      (fire && (st != ST_OK)) |=> ((state_ff == SEQ_IDLE) && err_ff && out_last))
      else $error("error pixel did not end the byte");

   a_pixel_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == SEQ_EMIT) && !is24_ff) |-> (pix_ff <= last_pix))
      else $error("pixel count ran past the byte");

   a_color_pixel_single: assert property (@(posedge clock) disable iff (reset)
      (fire && is24_ff) |=> (out_last && (state_ff == SEQ_IDLE)))
      else $error("24 bit byte gave more than one pixel");

endmodule

// ===== rtl/bmp_pixel_array_decoder.sv =====
// ----------------------------------------------------------------------------
// bmp_pixel_array_decoder
// Decodes BMP pixel array bytes into RGB pixels through a loadable palette
// (1/2/4/8 bpp) or direct B,G,R assembly (24 bpp), skipping row padding.
//
//   channel  dir  handshake              payload
//   req_     in   tvalid/tready          tdata: byte, pal index, R, G, B; tuser: op
//   rsp_     out  tvalid/tready, tlast   tdata: R, G, B, column; tuser: row_end, status
//   csr_     in   we                     addr, wdata
//
// A palette write, new frame or ignored word is taken in the idle state. A
// pixel byte passes a decode state, then an emit state per pixel it yields;
// the palette read port steps one index per cycle unless a stalled rsp_
// holds the pixel loop; the last pixel waits in the output register while
// the next word is taken. Reset is synchronous and clears counters and the
// error flag; the palette holds no reset value and needs no clearing pass.
// ----------------------------------------------------------------------------
module bmp_pixel_array_decoder
   import bmpad_pkg::*;
#(
   parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
   parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [39:0]           req_tdata,   // data_byte, palette_index, palette_red,
                                              // palette_green, palette_blue
   input  logic [1:0]            req_tuser,   // op
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [39:0]           rsp_tdata,   // red, green, blue, pixel_column, zero fill
   output logic                  rsp_tlast,   // last
   output logic [2:0]            rsp_tuser,   // row_end, status
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ADDR_W = $clog2(PALETTE_DEPTH);

   cfg_type              cfg_ff, cfg_in;
   pal_wr_type           pal_wr;
   logic [ADDR_W-1:0]    pal_rd_addr;
   logic [COLOR_W-1:0]   pal_color;
   logic [COLOR_W-1:0]   out_color;
   logic [PIX_COL_W-1:0] out_column;
   logic                 out_row_end;
   logic [STATUS_W-1:0]  out_status;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_DEPTH_MODE:  cfg_in.depth_mode      = csr_wdata[DEPTH_MODE_W-1:0];
            CSR_IMAGE_WIDTH: cfg_in.image_width     = csr_wdata[IMG_WIDTH_W-1:0];
            CSR_COLORS:      cfg_in.colors_in_table = csr_wdata[COLORS_W-1:0];
            CSR_GRAY_ONLY:   cfg_in.gray_only       = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.depth_mode      <= MODE_24BPP;
         cfg_ff.image_width     <= IMG_WIDTH_W'(1);
         cfg_ff.colors_in_table <= '0;
         cfg_ff.gray_only       <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bmpad_palette #(
      .PALETTE_DEPTH(PALETTE_DEPTH)
   ) u_palette (
      .clock    (clock),
      .wr       (pal_wr),
      .rd_addr  (pal_rd_addr),
      .rd_color (pal_color)
   );

   bmpad_seq #(
      .MAX_WIDTH    (MAX_WIDTH),
      .PALETTE_DEPTH(PALETTE_DEPTH)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_op        (req_tuser),
      .in_data_byte (req_tdata[7:0]),
      .in_pal_index (req_tdata[15:8]),
      .in_pal_color ({req_tdata[23:16], req_tdata[31:24], req_tdata[39:32]}),
      .pal_wr       (pal_wr),
      .pal_rd_addr  (pal_rd_addr),
      .pal_color    (pal_color),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_color    (out_color),
      .out_column   (out_column),
      .out_row_end  (out_row_end),
      .out_last     (rsp_tlast),
      .out_status   (out_status)
   );

   assign rsp_tdata = {4'd0, out_column, out_color[7:0], out_color[15:8], out_color[23:16]};
   assign rsp_tuser = {out_status, out_row_end};

endmodule
